// File: src/acs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants for the alignment column statistics block.
// ----------------------------------------------------------------------------
package acs_pkg;

    // Field widths of the column and result transfers
    localparam int SYM_W   = 8;
    localparam int EDIT_W  = 17;
    localparam int SCORE_W = 18;
    localparam int MEAN_W  = 33;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_SYMBOL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_PEN_CAP = 2'd2;

    // Configuration reset values
    localparam logic [SYM_W-1:0] GAP_SYMBOL_RST  = 8'd45;
    localparam logic [SYM_W-1:0] MATCH_CODE_RST  = 8'd124;
    localparam logic [SYM_W-1:0] GAP_PEN_CAP_RST = 8'd10;

    // Controller states
    typedef enum logic [3:0] {
        ST_ACCEPT  = 4'b0001,
        ST_FINAL   = 4'b0010,
        ST_DIVIDE  = 4'b0100,
        ST_PUBLISH = 4'b1000
    } acs_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic col_en;
        logic finalize;
        logic div_step;
        logic publish;
    } acs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } acs_status_t;

endpackage
`default_nettype wire

// File: src/acs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_ctrl
// Sequencer: takes columns, runs finalization and division on the last
// column, and owns the result valid flag.
// ----------------------------------------------------------------------------
module acs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_last_column,
    output logic                     s_ready,
    input  wire logic                m_ready,
    output logic                     m_valid,
    input  wire acs_pkg::acs_status_t status,
    output acs_pkg::acs_cmd_t         cmd
);
    import acs_pkg::*;

    acs_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_ACCEPT: begin
                s_ready    = 1'b1;
                cmd.col_en = s_valid;
                if (s_valid && s_last_column) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.finalize = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_ACCEPT;
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // Set valid on publish, drop it on the result transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// File: src/acs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_datapath
// Configuration registers, saturating column counters, restoring divider
// for the mean run length, and the result register.
// ----------------------------------------------------------------------------
module acs_datapath #(
    parameter int MAX_COLUMNS   = 65536,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire acs_pkg::acs_cmd_t                 cmd,
    output acs_pkg::acs_status_t                   status,
    input  wire logic [acs_pkg::SYM_W-1:0]         target_symbol,
    input  wire logic [acs_pkg::SYM_W-1:0]         query_symbol,
    input  wire logic [acs_pkg::SYM_W-1:0]         midline_symbol,
    input  wire logic                              cfg_we,
    input  wire logic [acs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [acs_pkg::SYM_W-1:0]         cfg_data,
    output logic [acs_pkg::EDIT_W-1:0]             edit_total,
    output logic signed [acs_pkg::SCORE_W-1:0]     modified_score,
    output logic [acs_pkg::MEAN_W-1:0]             mean_run_length
);
    import acs_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS + 1);      // counter width
    localparam int SW  = CW + 1;                       // signed score width
    localparam int PW  = (CW > SYM_W) ? CW : SYM_W;    // penalty compare width
    localparam int DW  = CW + FRACTION_BITS;           // dividend width
    localparam int SCW = $clog2(DW);                   // divider step count width
    localparam logic [CW-1:0]        CMAX      = CW'(MAX_COLUMNS);
    localparam logic signed [SW:0]   SMAX      = (SW + 1)'(MAX_COLUMNS);
    localparam logic signed [SW:0]   SMIN      = -SMAX;
    localparam logic [SCW-1:0]       LAST_STEP = SCW'(DW - 1);

    // Configuration
    logic [SYM_W-1:0] gap_symbol_reg, gap_symbol_next;
    logic [SYM_W-1:0] match_code_reg, match_code_next;
    logic [SYM_W-1:0] pen_cap_reg, pen_cap_next;

    // Accumulators
    logic [CW-1:0]        open_gap_reg, open_gap_next;
    logic [CW-1:0]        edit_reg, edit_next;
    logic signed [SW-1:0] score_reg, score_next;
    logic [CW-1:0]        cur_run_reg, cur_run_next;
    logic [CW-1:0]        run_sum_reg, run_sum_next;
    logic [CW-1:0]        run_cnt_reg, run_cnt_next;

    // Divider
    logic [CW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [CW-1:0]  divisor_reg, divisor_next;
    logic [SCW-1:0] step_reg, step_next;

    // Result register
    logic [EDIT_W-1:0]         edit_out_reg, edit_out_next;
    logic signed [SCORE_W-1:0] score_out_reg, score_out_next;
    logic [MEAN_W-1:0]         mean_out_reg, mean_out_next;

    // Column decode
    logic                 is_gap, gap_ended, mismatch, is_match;
    logic [CW-1:0]        penalty;
    logic [1:0]           edit_inc;
    logic signed [SW-1:0] score_mid;
    logic [CW-1:0]        fin_sum, fin_cnt;
    logic [CW:0]          trial;
    logic                 trial_ge;

    function automatic logic [CW-1:0] sat_cnt(input logic [CW:0] s);
        return (s > {1'b0, CMAX}) ? CMAX : s[CW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat_score(input logic signed [SW:0] v);
        logic signed [SW:0] c;
        c = v;
        if (v > SMAX) begin
            c = SMAX;
        end else if (v < SMIN) begin
            c = SMIN;
        end
        return c[SW-1:0];
    endfunction

    // Configuration writes
    always_comb begin
        gap_symbol_next = gap_symbol_reg;
        match_code_next = match_code_reg;
        pen_cap_next    = pen_cap_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAP_SYMBOL:  gap_symbol_next = cfg_data;
                CFG_MATCH_CODE:  match_code_next = cfg_data;
                CFG_GAP_PEN_CAP: pen_cap_next    = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Classify the column and form the score steps
    always_comb begin
        is_gap    = (target_symbol == gap_symbol_reg) || (query_symbol == gap_symbol_reg);
        gap_ended = !is_gap && (open_gap_reg != '0);
        mismatch  = !is_gap && (target_symbol != query_symbol);
        is_match  = (midline_symbol == match_code_reg);
        penalty   = (PW'(open_gap_reg) < PW'(pen_cap_reg)) ? open_gap_reg : CW'(pen_cap_reg);
        edit_inc  = {1'b0, gap_ended} + {1'b0, mismatch};
        score_mid = gap_ended
                  ? sat_score($signed({score_reg[SW-1], score_reg}) - $signed({2'b00, penalty}))
                  : score_reg;
    end

    // Finalize the open match run
    always_comb begin
        fin_sum = sat_cnt({1'b0, run_sum_reg} + {1'b0, cur_run_reg});
        fin_cnt = run_cnt_reg;
        if ((cur_run_reg != '0) || (run_cnt_reg == '0)) begin
            fin_cnt = sat_cnt({1'b0, run_cnt_reg} + (CW + 1)'(1));
        end
    end

    // Accumulator updates
    always_comb begin
        open_gap_next = open_gap_reg;
        edit_next     = edit_reg;
        score_next    = score_reg;
        cur_run_next  = cur_run_reg;
        run_sum_next  = run_sum_reg;
        run_cnt_next  = run_cnt_reg;
        priority if (cmd.publish) begin
            open_gap_next = '0;
            edit_next     = '0;
            score_next    = '0;
            cur_run_next  = '0;
            run_sum_next  = '0;
            run_cnt_next  = '0;
        end else if (cmd.col_en) begin
            if (is_gap) begin
                open_gap_next = sat_cnt({1'b0, open_gap_reg} + (CW + 1)'(1));
            end else begin
                open_gap_next = '0;
                edit_next     = sat_cnt({1'b0, edit_reg} + (CW + 1)'(edit_inc));
                score_next    = sat_score({score_mid[SW-1], score_mid}
                                          + (mismatch ? -(SW + 1)'(1) : (SW + 1)'(1)));
            end
            if (is_match) begin
                cur_run_next = sat_cnt({1'b0, cur_run_reg} + (CW + 1)'(1));
            end else begin
                run_sum_next = sat_cnt({1'b0, run_sum_reg} + {1'b0, cur_run_reg});
                if (cur_run_reg != '0) begin
                    run_cnt_next = sat_cnt({1'b0, run_cnt_reg} + (CW + 1)'(1));
                end
                cur_run_next = '0;
            end
        end else begin
            // hold all counters
        end
    end

    // Restoring divider, one quotient bit per step
    always_comb begin
        trial        = {rem_reg, quo_reg[DW-1]};
        trial_ge     = (trial >= {1'b0, divisor_reg});
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        priority if (cmd.finalize) begin
            rem_next     = '0;
            quo_next     = DW'(fin_sum) << FRACTION_BITS;
            divisor_next = fin_cnt;
            step_next    = '0;
        end else if (cmd.div_step) begin
            rem_next  = trial_ge ? CW'(trial - {1'b0, divisor_reg}) : trial[CW-1:0];
            quo_next  = {quo_reg[DW-2:0], trial_ge};
            step_next = step_reg + SCW'(1);
        end else begin
            // hold the divider
        end
    end

    assign status.div_done = cmd.div_step && (step_reg == LAST_STEP);

    // Load the result register
    always_comb begin
        edit_out_next  = edit_out_reg;
        score_out_next = score_out_reg;
        mean_out_next  = mean_out_reg;
        if (cmd.publish) begin
            edit_out_next  = EDIT_W'(edit_reg);
            score_out_next = SCORE_W'(score_reg);
            mean_out_next  = MEAN_W'(quo_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_symbol_reg <= GAP_SYMBOL_RST;
            match_code_reg <= MATCH_CODE_RST;
            pen_cap_reg    <= GAP_PEN_CAP_RST;
            open_gap_reg   <= '0;
            edit_reg       <= '0;
            score_reg      <= '0;
            cur_run_reg    <= '0;
            run_sum_reg    <= '0;
            run_cnt_reg    <= '0;
        end else begin
            gap_symbol_reg <= gap_symbol_next;
            match_code_reg <= match_code_next;
            pen_cap_reg    <= pen_cap_next;
            open_gap_reg   <= open_gap_next;
            edit_reg       <= edit_next;
            score_reg      <= score_next;
            cur_run_reg    <= cur_run_next;
            run_sum_reg    <= run_sum_next;
            run_cnt_reg    <= run_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        divisor_reg   <= divisor_next;
        step_reg      <= step_next;
        edit_out_reg  <= edit_out_next;
        score_out_reg <= score_out_next;
        mean_out_reg  <= mean_out_next;
    end

    assign edit_total      = edit_out_reg;
    assign modified_score  = score_out_reg;
    assign mean_run_length = mean_out_reg;

endmodule
`default_nettype wire

// File: src/alignment_column_statistics_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alignment_column_statistics_top
// Alignment column statistics: edit count, modified score, mean match run.
// ----------------------------------------------------------------------------
// Usage:
//   Columns enter on the s_ channel, one transfer per cycle while s_ready is
//   high. Non-last columns only update the counters and produce no result.
//   A column with s_last_column set produces one result on the m_ channel.
//   After the last-column transfer s_ready drops while the block closes the
//   open match run, runs the one-bit-per-cycle restoring divider over DW
//   quotient bits, where DW = clog2(MAX_COLUMNS + 1) + FRACTION_BITS (33 at
//   the defaults), and then loads the result register and clears the
//   counters. m_valid rises in the cycle after that load.
//   The result register parts the two sides: columns of the next alignment
//   are taken while a result waits. If the receiver still holds the previous
//   result when the next division ends, the block waits until it is taken.
//   Configuration writes on the cfg_ channel are always accepted (cfg_ready
//   is tied high) and are meant for idle periods only.
//   Synchronous active-low reset restores register defaults (gap 45, match
//   124, cap 10), clears the column counters and drops m_valid.
// ----------------------------------------------------------------------------
module alignment_column_statistics_top #(
    parameter int MAX_COLUMNS   = 65536,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [acs_pkg::SYM_W-1:0]     s_target_symbol,
    input  wire logic [acs_pkg::SYM_W-1:0]     s_query_symbol,
    input  wire logic [acs_pkg::SYM_W-1:0]     s_midline_symbol,
    input  wire logic                          s_last_column,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [acs_pkg::EDIT_W-1:0]         m_edit_total,
    output logic signed [acs_pkg::SCORE_W-1:0] m_modified_score,
    output logic [acs_pkg::MEAN_W-1:0]         m_mean_run_length,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [acs_pkg::SYM_W-1:0]     cfg_data
);
    import acs_pkg::*;

    acs_cmd_t    cmd;
    acs_status_t status;

    // Take configuration writes in any cycle
    assign cfg_ready = 1'b1;

    acs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_last_column (s_last_column),
        .s_ready       (s_ready),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .status        (status),
        .cmd           (cmd)
    );

    acs_datapath #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .target_symbol   (s_target_symbol),
        .query_symbol    (s_query_symbol),
        .midline_symbol  (s_midline_symbol),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .edit_total      (m_edit_total),
        .modified_score  (m_modified_score),
        .mean_run_length (m_mean_run_length)
    );

endmodule
`default_nettype wire

// File: src/acs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks on the column statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module acs_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          s_last_column,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [acs_pkg::EDIT_W-1:0]    m_edit_total,
    input wire logic [acs_pkg::SCORE_W-1:0]   m_modified_score,
    input wire logic [acs_pkg::MEAN_W-1:0]    m_mean_run_length
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_edit_total)
            && $stable(m_modified_score) && $stable(m_mean_run_length))
        else $error("stalled result changed");

    // Stall the column channel after a last-column transfer
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_column |=> !s_ready)
        else $error("column accepted during finalization");

    // Keep streaming after an ordinary column
    a_stream_on: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_column |=> s_ready)
        else $error("column channel stalled mid-alignment");

    // Drop the result after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind alignment_column_statistics_top acs_checker u_acs_checker (.*);
`default_nettype wire
